>>> rtl/fwrm_pkg.sv
// shared types and constants for the fifo with running max
`default_nettype none
package fwrm_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] data_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     popped_valid;
    logic signed [DATA_W-1:0] current_max;
    logic                     max_valid;
    logic                     push_overflow;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REFILL,
    S_SETTLE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic push_write;
    logic drop_tail;
    logic pop;
    logic flag_overflow;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic v_empty;
    logic c_empty;
    logic tail_less;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/fwrm_ctrl.sv
// sequencer for push, candidate tail removal and pop
`default_nettype none
module fwrm_ctrl import fwrm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output logic      busy,
  output logic      done,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && ((state == S_IDLE) || (state == S_DONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE, S_DONE: begin
        state_next = accept ? S_EXEC : S_IDLE;
      end
      S_EXEC: begin
        if (!sts.is_pop && !sts.full && !sts.c_empty && sts.tail_less) begin
          state_next = S_REFILL;
        end else begin
          state_next = S_SETTLE;
        end
      end
      S_REFILL: state_next = S_EXEC;
      S_SETTLE: state_next = S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    cmd.load = accept;
    case (state)
      S_IDLE: busy = 1'b0;
      S_DONE: begin
        busy = 1'b0;
        done = 1'b1;
      end
      S_EXEC: begin
        if (sts.is_pop) begin
          cmd.pop = !sts.v_empty;
        end else if (sts.full) begin
          cmd.flag_overflow = 1'b1;
        end else if (!sts.c_empty && sts.tail_less) begin
          cmd.drop_tail = 1'b1;
        end else begin
          cmd.push_write = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/fwrm_dp.sv
// value and candidate stores with pointers, counts and result registers
`default_nettype none
module fwrm_dp import fwrm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire cmd_t  cmd,
  output sts_t       sts,
  output result_t    result
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A = AW'(QUEUE_DEPTH - 1);

  logic [DATA_W-1:0] vmem [QUEUE_DEPTH];
  logic [DATA_W-1:0] cmem [QUEUE_DEPTH];

  op_t                      op_q;
  logic signed [DATA_W-1:0] data_q;
  logic [AW-1:0]            v_head;
  logic [CW-1:0]            v_count;
  logic [AW-1:0]            c_head;
  logic [CW-1:0]            c_count;
  logic signed [DATA_W-1:0] rd_tail;
  logic signed [DATA_W-1:0] rd_head;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] popped_value;
  logic                     popped_valid;
  logic                     overflow;

  logic [SW-1:0] v_wr_sum;
  logic [SW-1:0] c_wr_sum;
  logic [SW-1:0] c_tl_sum;
  logic [AW-1:0] v_wr;
  logic [AW-1:0] c_wr;
  logic [AW-1:0] c_tail;
  logic [CW-1:0] c_count_m1;
  logic          max_valid;

  assign c_count_m1 = c_count - CW'(1);
  assign v_wr_sum   = {1'b0, v_head} + SW'(v_count);
  assign c_wr_sum   = {1'b0, c_head} + SW'(c_count);
  assign c_tl_sum   = {1'b0, c_head} + SW'(c_count_m1);
  assign v_wr   = (v_wr_sum >= DEPTH_S) ? AW'(v_wr_sum - DEPTH_S) : AW'(v_wr_sum);
  assign c_wr   = (c_wr_sum >= DEPTH_S) ? AW'(c_wr_sum - DEPTH_S) : AW'(c_wr_sum);
  assign c_tail = (c_tl_sum >= DEPTH_S) ? AW'(c_tl_sum - DEPTH_S) : AW'(c_tl_sum);

  // storage with registered read ports
  always_ff @(posedge clk) begin
    if (cmd.push_write) begin
      vmem[v_wr] <= data_q;
      cmem[c_wr] <= data_q;
    end
    rd_tail <= cmem[c_tail];
    rd_head <= cmem[c_head];
    rd_val  <= vmem[v_head];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(item.opcode);
      data_q <= item.data_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_head       <= '0;
      v_count      <= '0;
      c_head       <= '0;
      c_count      <= '0;
      popped_value <= '0;
      popped_valid <= 1'b0;
      overflow     <= 1'b0;
    end else begin
      if (cmd.load) begin
        popped_value <= '0;
        popped_valid <= 1'b0;
        overflow     <= 1'b0;
      end
      if (cmd.flag_overflow) begin
        overflow <= 1'b1;
      end
      if (cmd.drop_tail) begin
        c_count <= c_count_m1;
      end
      if (cmd.push_write) begin
        v_count <= v_count + CW'(1);
        c_count <= c_count + CW'(1);
      end
      if (cmd.pop) begin
        popped_value <= rd_val;
        popped_valid <= 1'b1;
        v_head       <= (v_head == LAST_A) ? '0 : v_head + AW'(1);
        v_count      <= v_count - CW'(1);
        if ((c_count != '0) && (rd_head == rd_val)) begin
          c_head  <= (c_head == LAST_A) ? '0 : c_head + AW'(1);
          c_count <= c_count_m1;
        end
      end
    end
  end

  assign sts.is_pop    = (op_q == OP_POP);
  assign sts.full      = (v_count == DEPTH_C);
  assign sts.v_empty   = (v_count == '0);
  assign sts.c_empty   = (c_count == '0);
  assign sts.tail_less = (rd_tail < data_q);

  assign max_valid = (v_count != '0) && (c_count != '0);

  assign result.popped_value  = popped_value;
  assign result.popped_valid  = popped_valid;
  assign result.current_max   = max_valid ? rd_head : '0;
  assign result.max_valid     = max_valid;
  assign result.push_overflow = overflow;

endmodule
`default_nettype wire

>>> rtl/fifo_with_running_max_core.sv
// fifo of signed words that reports its running maximum
// result strobe: after the accepting edge the sequencer passes through exec, settle and done, and each
// smaller candidate a push removes from the candidate tail adds a pass through refill back to exec
// overlap: a new item is accepted only in idle or done; removals amortize to one per push
// the candidate tail compare loop through the registered store read sets the pace of removals
// reset: synchronous, clears pointers, counts, result registers and control; stores hold no reset value
`default_nettype none
module fifo_with_running_max_core import fwrm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output logic       done,
  output result_t    result
);

  cmd_t cmd;
  sts_t sts;

  fwrm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  fwrm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  a_no_back_to_back_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on consecutive cycles");

  a_accept_not_immediate: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("beat accepted without entering execution");

  a_overflow_has_max: assert property (@(posedge clk) disable iff (rst)
    (done && result.push_overflow) |-> result.max_valid)
    else $error("full queue reported without a maximum");

  a_pop_not_overflow: assert property (@(posedge clk) disable iff (rst)
    (done && result.popped_valid) |-> !result.push_overflow)
    else $error("pop and overflow flagged together");

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench for fifo_with_running_max_core: push and pop beats checked against a queue model
module testbench import fwrm_pkg::*;;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam int RANDOM_BEATS = 1100;
  localparam int DRAIN_CYCLES = 3 + 2 * DEPTH + 8;

  typedef enum int {
    VAL_WIDE,
    VAL_NARROW,
    VAL_EDGE,
    VAL_RAMP_UP,
    VAL_RAMP_DOWN
  } value_style_e;

  class max_queue_scoreboard;
    logic signed [DATA_W-1:0] held_values[$];
    logic signed [DATA_W-1:0] max_candidates[$];
    result_t expected_results[$];
    int error_count;

    function result_t predict_result(item_t it);
      result_t r;
      logic signed [DATA_W-1:0] v;
      r = '0;
      v = it.data_value;
      if (it.opcode == OP_PUSH) begin
        if (held_values.size() >= DEPTH) begin
          r.push_overflow = 1'b1;
        end else begin
          // only strictly smaller candidates leave the tail
          while (max_candidates.size() > 0 && max_candidates[$] < v)
            max_candidates.delete(max_candidates.size() - 1);
          max_candidates.insert(max_candidates.size(), v);
          held_values.insert(held_values.size(), v);
        end
      end else if (held_values.size() > 0) begin
        r.popped_value = held_values[0];
        held_values.delete(0);
        r.popped_valid = 1'b1;
        if (max_candidates.size() > 0 && max_candidates[0] == r.popped_value)
          max_candidates.delete(0);
      end
      if (held_values.size() > 0 && max_candidates.size() > 0) begin
        r.current_max = max_candidates[0];
        r.max_valid = 1'b1;
      end
      return r;
    endfunction

    function void note_item(item_t it);
      expected_results.insert(expected_results.size(), predict_result(it));
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      error_count++;
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no beat pending", 0, got.popped_value);
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      if (got.popped_value !== want.popped_value)
        report_mismatch("popped_value", want.popped_value, got.popped_value);
      if (got.popped_valid !== want.popped_valid)
        report_mismatch("popped_valid", DATA_W'(want.popped_valid),
                        DATA_W'(got.popped_valid));
      if (got.current_max !== want.current_max)
        report_mismatch("current_max", want.current_max, got.current_max);
      if (got.max_valid !== want.max_valid)
        report_mismatch("max_valid", DATA_W'(want.max_valid), DATA_W'(got.max_valid));
      if (got.push_overflow !== want.push_overflow)
        report_mismatch("push_overflow", DATA_W'(want.push_overflow),
                        DATA_W'(got.push_overflow));
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  max_queue_scoreboard fifo_max_sb = new();

  int burst_left;
  int phase_len;
  int push_pct;
  int waited;
  value_style_e style;
  logic signed [DATA_W-1:0] ramp_value;

  fifo_with_running_max_core #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        fifo_max_sb.check_result(result);
      if (start && !busy)
        fifo_max_sb.note_item(item);
    end
  end

  function automatic logic [DATA_W-1:0] pick_value(value_style_e s);
    logic [DATA_W-1:0] v;
    case (s)
      VAL_NARROW: v = $urandom_range(0, 8) - 4;
      VAL_EDGE: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0001;
          3: v = 32'h7fff_fffe;
          4: v = 32'hffff_ffff;
          default: v = '0;
        endcase
      end
      VAL_RAMP_UP: begin
        ramp_value = ramp_value + $signed($urandom_range(0, 3));
        v = ramp_value;
      end
      VAL_RAMP_DOWN: begin
        ramp_value = ramp_value - $signed($urandom_range(0, 3));
        v = ramp_value;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_beat(op_t op, logic [DATA_W-1:0] value);
    item_t next;
    next.opcode = op;
    next.data_value = value;
    item <= next;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_paced(op_t op, logic [DATA_W-1:0] value);
    int gap;
    item_t noise;
    send_beat(op, value);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (gap > 0) begin
        noise.opcode = 1'($urandom_range(0, 1));
        noise.data_value = $urandom;
        start <= 1'b0;
        item <= noise;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic run_directed();
    send_paced(OP_POP, 32'hdead_beef);
    send_paced(OP_PUSH, 32'h8000_0000);
    send_paced(OP_PUSH, 32'h7fff_ffff);
    send_paced(OP_PUSH, 32'h7fff_ffff);
    send_paced(OP_PUSH, 32'h0000_0000);
    send_paced(OP_POP, 32'hffff_ffff);
    // equal maxima: one copy stays after this pop
    send_paced(OP_POP, 32'h0000_0000);
    // descending fill leaves both queues full
    for (int i = 1; i <= 14; i++)
      send_paced(OP_PUSH, -i);
    send_paced(OP_PUSH, 32'h7fff_ffff);
    send_paced(OP_POP, 32'h1234_5678);
    // long tail sweep of the candidate queue
    send_paced(OP_PUSH, 32'h7fff_fffe);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    ramp_value = '0;
    burst_left = $urandom_range(1, 8);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (int n = 0; n < RANDOM_BEATS; n += phase_len) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: push_pct = 25;
        1: push_pct = 50;
        2: push_pct = 75;
        default: push_pct = 90;
      endcase
      style = value_style_e'($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0)
        ramp_value = $urandom;
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct)
          send_paced(OP_PUSH, pick_value(style));
        else
          send_paced(OP_POP, $urandom);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (fifo_max_sb.expected_results.size() != 0 && waited < 4 * DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fifo_max_sb.expected_results.size() != 0)
      fifo_max_sb.report_mismatch("results never returned",
                                  fifo_max_sb.expected_results.size(), 0);
    if (fifo_max_sb.error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
